/* rtl/core/bsia_pkg.sv */
// Package for the bounded stack with indexed access.
// Holds the operation, status, state and cell control types shared by the
// cell and the top level. Depends on nothing.
package bsia_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned TDATA_W = 40;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH     = 3'd0,
    KIND_POP      = 3'd1,
    KIND_PEEK     = 3'd2,
    KIND_CHANGE   = 3'd3,
    KIND_TRAVERSE = 3'd4
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_OVERFLOW = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_BEYOND   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ROTATE
  } state_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_SHIFT_UP
  } cell_op_e;

  typedef struct packed {
    cell_op_e            op;
    logic [DATA_W-1:0]   wrap_data;
  } cell_ctrl_t;

endpackage

/* rtl/core/bsia_cell.sv */
// One storage cell of the stack chain; cell 0 is the top of the stack.
// Shifts down on push, up on pop or rotation, and takes the wrapped top
// entry when it is the lowest occupied cell. Depends on bsia_pkg.
module bsia_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned IW    = 4
) (
  input  logic                        clk_i,
  input  bsia_pkg::cell_ctrl_t        ctrl_i,
  input  logic [IW-1:0]               last_idx_i,
  input  logic [bsia_pkg::DATA_W-1:0] above_data_i,
  input  logic [bsia_pkg::DATA_W-1:0] below_data_i,
  output logic [bsia_pkg::DATA_W-1:0] data_o
);

  logic [bsia_pkg::DATA_W-1:0] data_q;
  logic [bsia_pkg::DATA_W-1:0] data_d;
  logic                        is_last;

  assign is_last = (last_idx_i == IW'(INDEX));

  always_comb begin
    data_d = data_q;
    unique case (ctrl_i.op)
      bsia_pkg::CELL_PUSH: begin
        data_d = above_data_i;
      end
      bsia_pkg::CELL_SHIFT_UP: begin
        data_d = is_last ? ctrl_i.wrap_data : below_data_i;
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

/* rtl/core/bounded_stack_with_indexed_access.sv */
// Top level of the bounded stack with indexed access.
// Builds the cell chain from bsia_cell and runs it with a small sequencer.
// Depends on bsia_pkg and bsia_cell.
//
// Usage: the slave channel carries one operation per item, its kind in
// s_axis_tuser and value and position in s_axis_tdata. The master channel
// returns results with status in m_axis_tuser, data and count in
// m_axis_tdata, and tlast on the final result of an operation.
// Entries live in a chain of cells with the top in cell 0. Push and pop
// shift the whole chain at once in the EXEC state, which also registers
// their result before the sequencer returns to idle for the next item.
// Peek, change and traverse rotate the occupied cells once around, one
// step per cycle while the receiver does not stall a step that must emit a
// result; a traverse emits one result per step. An empty stack and every
// error case end in the EXEC state without a rotation.
// One operation is in work at a time; a new item is taken while the last
// result still waits in the output register.
// Reset empties the stack and drops any pending result. When the receiver
// stalls, the rotation holds on steps that must emit a result, and no
// result is lost.
module bounded_stack_with_indexed_access #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [bsia_pkg::TDATA_W-1:0]        s_axis_tdata,   // value, position
  input  logic [bsia_pkg::KIND_W-1:0]         s_axis_tuser,   // kind
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [bsia_pkg::TDATA_W-1:0]        m_axis_tdata,   // data, count
  output logic [bsia_pkg::STAT_W-1:0]         m_axis_tuser,   // status
  output logic                                m_axis_tlast
);

  localparam int unsigned IW    = $clog2(STACK_DEPTH);
  localparam int unsigned CW    = $clog2(STACK_DEPTH + 1);
  localparam int unsigned CMP_W = (CW > bsia_pkg::POS_W) ? CW : bsia_pkg::POS_W;
  localparam int unsigned DW    = bsia_pkg::DATA_W;

  bsia_pkg::state_e      state_q, state_d;
  bsia_pkg::kind_e       kind_q;
  logic [DW-1:0]         value_q;
  logic [bsia_pkg::POS_W-1:0] pos_q, pos_in;
  logic [CW-1:0]         count_q, count_d;
  logic [IW-1:0]         step_q, step_d;
  logic [DW-1:0]         peek_q, peek_d;

  logic                  out_valid_q, out_valid_d;
  bsia_pkg::status_e     out_status_q, out_status_d;
  logic [DW-1:0]         out_data_q, out_data_d;
  logic [bsia_pkg::CNT_W-1:0] out_count_q, out_count_d;
  logic                  out_last_q, out_last_d;

  bsia_pkg::cell_ctrl_t  cell_ctrl;
  logic [DW-1:0]         cell_data [STACK_DEPTH];
  logic [IW-1:0]         last_idx;
  logic                  in_fire;
  logic                  out_free;
  logic                  last_step;
  logic                  hit;
  logic                  need_out;
  logic [CMP_W-1:0]      count_ext, count_d_ext, pos_ext, step_ext;

  assign s_axis_tready = (state_q == bsia_pkg::ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign pos_in = (s_axis_tdata[36:32] == '0) ? bsia_pkg::POS_W'(1) : s_axis_tdata[36:32];

  assign last_idx    = IW'(count_q - CW'(1));
  assign count_ext   = CMP_W'(count_q);
  assign count_d_ext = CMP_W'(count_d);
  assign pos_ext     = CMP_W'(pos_q);
  assign step_ext    = CMP_W'(step_q) + CMP_W'(1);
  assign last_step   = (step_q == last_idx);
  assign hit         = (step_ext == pos_ext);
  assign need_out    = (kind_q == bsia_pkg::KIND_TRAVERSE) || last_step;

  always_comb begin
    state_d             = state_q;
    count_d             = count_q;
    step_d              = step_q;
    peek_d              = peek_q;
    cell_ctrl.op        = bsia_pkg::CELL_HOLD;
    cell_ctrl.wrap_data = cell_data[0];
    out_valid_d         = out_valid_q && !m_axis_tready;
    out_status_d        = out_status_q;
    out_data_d          = out_data_q;
    out_count_d         = out_count_q;
    out_last_d          = out_last_q;

    unique case (state_q)
      bsia_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = bsia_pkg::ST_EXEC;
        end
      end
      bsia_pkg::ST_EXEC: begin
        if (out_free) begin
          state_d      = bsia_pkg::ST_IDLE;
          out_status_d = bsia_pkg::STAT_OK;
          out_data_d   = '0;
          out_last_d   = 1'b1;
          out_valid_d  = 1'b1;
          step_d       = '0;
          unique case (kind_q)
            bsia_pkg::KIND_PUSH: begin
              if (count_q == CW'(STACK_DEPTH)) begin
                out_status_d = bsia_pkg::STAT_OVERFLOW;
              end else begin
                cell_ctrl.op = bsia_pkg::CELL_PUSH;
                count_d      = count_q + CW'(1);
              end
            end
            bsia_pkg::KIND_POP: begin
              if (count_q == '0) begin
                out_status_d = bsia_pkg::STAT_EMPTY;
              end else begin
                cell_ctrl.op = bsia_pkg::CELL_SHIFT_UP;
                count_d      = count_q - CW'(1);
              end
            end
            bsia_pkg::KIND_PEEK, bsia_pkg::KIND_CHANGE: begin
              if (count_q == '0) begin
                out_status_d = bsia_pkg::STAT_EMPTY;
              end else if (pos_ext > count_ext) begin
                out_status_d = bsia_pkg::STAT_BEYOND;
              end else begin
                out_valid_d = out_valid_q && !m_axis_tready;
                state_d     = bsia_pkg::ST_ROTATE;
              end
            end
            bsia_pkg::KIND_TRAVERSE: begin
              if (count_q == '0) begin
                out_status_d = bsia_pkg::STAT_EMPTY;
              end else begin
                out_valid_d = out_valid_q && !m_axis_tready;
                state_d     = bsia_pkg::ST_ROTATE;
              end
            end
            default: begin
              out_status_d = bsia_pkg::STAT_OK;
            end
          endcase
          out_count_d = count_d_ext[bsia_pkg::CNT_W-1:0];
        end
      end
      bsia_pkg::ST_ROTATE: begin
        if (!need_out || out_free) begin
          cell_ctrl.op = bsia_pkg::CELL_SHIFT_UP;
          if (kind_q == bsia_pkg::KIND_CHANGE && hit) begin
            cell_ctrl.wrap_data = value_q;
          end
          if (kind_q == bsia_pkg::KIND_PEEK && hit) begin
            peek_d = cell_data[0];
          end
          if (need_out) begin
            out_valid_d  = 1'b1;
            out_status_d = bsia_pkg::STAT_OK;
            out_count_d  = count_ext[bsia_pkg::CNT_W-1:0];
            out_last_d   = last_step;
            priority if (kind_q == bsia_pkg::KIND_TRAVERSE) begin
              out_data_d = cell_data[0];
            end else if (kind_q == bsia_pkg::KIND_CHANGE) begin
              out_data_d = value_q;
            end else begin
              out_data_d = hit ? cell_data[0] : peek_q;
            end
          end
          if (last_step) begin
            state_d = bsia_pkg::ST_IDLE;
          end else begin
            step_d = step_q + IW'(1);
          end
        end
      end
      default: begin
        state_d = bsia_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bsia_pkg::ST_IDLE;
      count_q     <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q  <= bsia_pkg::kind_e'(s_axis_tuser);
      value_q <= s_axis_tdata[31:0];
      pos_q   <= pos_in;
    end
    peek_q       <= peek_d;
    out_status_q <= out_status_d;
    out_data_q   <= out_data_d;
    out_count_q  <= out_count_d;
    out_last_q   <= out_last_d;
  end

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [DW-1:0] above_data;
    logic [DW-1:0] below_data;
    if (i == 0) begin : g_top
      assign above_data = value_q;
    end else begin : g_mid
      assign above_data = cell_data[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign below_data = '0;
    end else begin : g_upper
      assign below_data = cell_data[i+1];
    end
    bsia_cell #(
      .INDEX (i),
      .IW    (IW)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (cell_ctrl),
      .last_idx_i   (last_idx),
      .above_data_i (above_data),
      .below_data_i (below_data),
      .data_o       (cell_data[i])
    );
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = bsia_pkg::TDATA_W'({out_count_q, out_data_q});
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(STACK_DEPTH))
    else $error("Stack count exceeds its depth.");

  a_rotate_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bsia_pkg::ST_ROTATE) |-> (CW'(step_q) < count_q))
    else $error("Rotation step is outside the occupied cells.");

  a_rotate_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bsia_pkg::ST_ROTATE) |=> $stable(count_q))
    else $error("Stack count changed during a rotation.");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != bsia_pkg::ST_EXEC) |=> $stable(count_q))
    else $error("Stack count changed outside an operation.");

endmodule

/* tb/testbench.sv */
// Testbench for the bounded stack with indexed access.
// Drives stack operations on the slave stream, mirrors the stack in a local predictor
// and checks every result on the master stream. Depends on bsia_pkg and the top level.
module testbench;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned IDLE_LIMIT  = 3000;

  typedef struct packed {
    bsia_pkg::status_e           status;
    logic [bsia_pkg::DATA_W-1:0] data;
    logic [bsia_pkg::CNT_W-1:0]  count;
    logic                        last;
  } stack_result_t;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [bsia_pkg::TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [bsia_pkg::KIND_W-1:0]   s_axis_tuser  = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [bsia_pkg::TDATA_W-1:0]  m_axis_tdata;
  logic [bsia_pkg::STAT_W-1:0]   m_axis_tuser;
  logic                          m_axis_tlast;

  logic [bsia_pkg::DATA_W-1:0]   stack_mirror [STACK_DEPTH];
  int unsigned                   held_count    = 0;
  stack_result_t                 pending_results [$];
  int unsigned                   error_count   = 0;
  int unsigned                   idle_cycles   = 0;
  int unsigned                   rx_hold_req   = 0;
  bit                            no_idle       = 1'b0;

  bounded_stack_with_indexed_access #(
    .STACK_DEPTH(STACK_DEPTH)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk_i = ~clk_i;

  function automatic stack_result_t make_result(bsia_pkg::status_e status,
                                                logic [bsia_pkg::DATA_W-1:0] data,
                                                logic last);
    stack_result_t r;
    r.status = status;
    r.data   = data;
    r.count  = held_count[bsia_pkg::CNT_W-1:0];
    r.last   = last;
    return r;
  endfunction

  // Applies one operation to the mirror and queues the results it should produce.
  function automatic void apply_stack_op(logic [bsia_pkg::KIND_W-1:0] kind,
                                         logic [bsia_pkg::DATA_W-1:0] value,
                                         logic [bsia_pkg::POS_W-1:0] pos);
    int unsigned depth;
    int unsigned idx;
    depth = (pos == 0) ? 1 : pos;
    case (kind)
      bsia_pkg::KIND_PUSH: begin
        if (held_count >= STACK_DEPTH) begin
          pending_results.push_back(make_result(bsia_pkg::STAT_OVERFLOW, '0, 1'b1));
        end else begin
          stack_mirror[held_count] = value;
          held_count++;
          pending_results.push_back(make_result(bsia_pkg::STAT_OK, '0, 1'b1));
        end
      end
      bsia_pkg::KIND_POP: begin
        if (held_count == 0) begin
          pending_results.push_back(make_result(bsia_pkg::STAT_EMPTY, '0, 1'b1));
        end else begin
          held_count--;
          pending_results.push_back(make_result(bsia_pkg::STAT_OK, '0, 1'b1));
        end
      end
      bsia_pkg::KIND_PEEK, bsia_pkg::KIND_CHANGE: begin
        if (held_count == 0) begin
          pending_results.push_back(make_result(bsia_pkg::STAT_EMPTY, '0, 1'b1));
        end else if (depth > held_count) begin
          pending_results.push_back(make_result(bsia_pkg::STAT_BEYOND, '0, 1'b1));
        end else begin
          idx = held_count - depth;
          if (kind == bsia_pkg::KIND_CHANGE) begin
            stack_mirror[idx] = value;
          end
          pending_results.push_back(make_result(bsia_pkg::STAT_OK, stack_mirror[idx],
                                                1'b1));
        end
      end
      bsia_pkg::KIND_TRAVERSE: begin
        if (held_count == 0) begin
          pending_results.push_back(make_result(bsia_pkg::STAT_EMPTY, '0, 1'b1));
        end else begin
          for (int k = 0; k < held_count; k++) begin
            pending_results.push_back(make_result(bsia_pkg::STAT_OK,
                                                  stack_mirror[held_count - 1 - k],
                                                  k + 1 == held_count));
          end
        end
      end
      default: begin
        pending_results.push_back(make_result(bsia_pkg::STAT_OK, '0, 1'b1));
      end
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_op(logic [bsia_pkg::KIND_W-1:0] kind,
                         logic [bsia_pkg::DATA_W-1:0] value,
                         logic [bsia_pkg::POS_W-1:0] pos);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {{(bsia_pkg::TDATA_W - bsia_pkg::DATA_W - bsia_pkg::POS_W){1'b0}},
                      pos, value};
    do @(posedge clk_i); while (!s_axis_tready);
    apply_stack_op(kind, value, pos);
    @(negedge clk_i);
  endtask

  function automatic logic [bsia_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_stack();
    send_op(bsia_pkg::KIND_POP, pick_value(), 5'd0);
    send_op(bsia_pkg::KIND_PEEK, pick_value(), 5'd1);
    send_op(bsia_pkg::KIND_CHANGE, pick_value(), 5'd0);
    send_op(bsia_pkg::KIND_TRAVERSE, pick_value(), 5'd0);
  endtask

  task automatic test_fill_and_index();
    send_op(bsia_pkg::KIND_PUSH, 32'h7FFF_FFFF, 5'd0);
    send_op(bsia_pkg::KIND_PUSH, 32'h8000_0000, 5'd0);
    send_op(bsia_pkg::KIND_PUSH, 32'h0000_0000, 5'd0);
    send_op(bsia_pkg::KIND_PUSH, 32'hFFFF_FFFF, 5'd0);
    for (int i = 4; i < STACK_DEPTH; i++) begin
      send_op(bsia_pkg::KIND_PUSH, $urandom, 5'($urandom_range(0, 31)));
    end
    send_op(bsia_pkg::KIND_PUSH, pick_value(), 5'd0);
    send_op(bsia_pkg::KIND_PEEK, pick_value(), 5'd0);
    send_op(bsia_pkg::KIND_PEEK, pick_value(), 5'd16);
    send_op(bsia_pkg::KIND_PEEK, pick_value(), 5'd17);
    send_op(bsia_pkg::KIND_CHANGE, 32'h8000_0000, 5'd16);
    send_op(bsia_pkg::KIND_TRAVERSE, pick_value(), 5'd0);
  endtask

  // The receiver stops for a long stretch while items keep coming back to back.
  task automatic test_backpressure();
    no_idle     = 1'b1;
    rx_hold_req = 80;
    for (int i = 0; i < 20; i++) begin
      case (i % 5)
        0, 2:    send_op(bsia_pkg::KIND_PUSH, pick_value(), 5'd0);
        1:       send_op(bsia_pkg::KIND_PEEK, pick_value(), 5'($urandom_range(0, 17)));
        3:       send_op(bsia_pkg::KIND_TRAVERSE, pick_value(), 5'd0);
        default: send_op(bsia_pkg::KIND_POP, pick_value(), 5'd0);
      endcase
    end
    no_idle = 1'b0;
  endtask

  task automatic test_random_ops();
    int unsigned                 r;
    int unsigned                 push_w;
    logic [bsia_pkg::KIND_W-1:0] kind;
    logic [bsia_pkg::POS_W-1:0]  pos;
    bit                          filling;
    filling = 1'b0;
    for (int i = 0; i < 330; i++) begin
      if (i % 60 == 0) begin
        filling = !filling;
      end
      no_idle = ((i / 45) % 3 == 2);
      push_w  = filling ? 45 : 15;
      r = $urandom_range(0, 99);
      if (r < 3) begin
        kind = 3'($urandom_range(5, 7));
      end else if (r < 3 + push_w) begin
        kind = bsia_pkg::KIND_PUSH;
      end else if (r < 63) begin
        kind = bsia_pkg::KIND_POP;
      end else if (r < 78) begin
        kind = bsia_pkg::KIND_PEEK;
      end else if (r < 90) begin
        kind = bsia_pkg::KIND_CHANGE;
      end else begin
        kind = bsia_pkg::KIND_TRAVERSE;
      end
      r = $urandom_range(0, 9);
      if (r == 0) begin
        pos = '0;
      end else if (r == 1) begin
        pos = 5'($urandom_range(17, 31));
      end else begin
        pos = 5'($urandom_range(1, (held_count < STACK_DEPTH) ? held_count + 1 : STACK_DEPTH));
      end
      send_op(kind, pick_value(), pos);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    int unsigned n;
    forever begin
      if (rx_hold_req != 0) begin
        n = rx_hold_req;
        rx_hold_req = 0;
      end else begin
        n = no_idle ? 0 : $urandom_range(0, 8);
      end
      if (n != 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(rst_ni && m_axis_tvalid));
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    stack_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10) begin
          $display("Unexpected result: status %0d data %h count %0d last %b",
                   m_axis_tuser, m_axis_tdata[bsia_pkg::DATA_W-1:0],
                   m_axis_tdata[bsia_pkg::DATA_W +: bsia_pkg::CNT_W], m_axis_tlast);
        end
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.status ||
            m_axis_tdata[bsia_pkg::DATA_W-1:0] !== want.data ||
            m_axis_tdata[bsia_pkg::DATA_W +: bsia_pkg::CNT_W] !== want.count ||
            m_axis_tlast !== want.last) begin
          error_count++;
          if (error_count <= 10) begin
            $display("Mismatch: expected status %0d data %h count %0d last %b",
                     want.status, want.data, want.count, want.last);
            $display("          got status %0d data %h count %0d last %b",
                     m_axis_tuser, m_axis_tdata[bsia_pkg::DATA_W-1:0],
                     m_axis_tdata[bsia_pkg::DATA_W +: bsia_pkg::CNT_W], m_axis_tlast);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_empty_stack();
    test_fill_and_index();
    test_backpressure();
    test_random_ops();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2 * STACK_DEPTH + 4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
